### hw/rtl/dsar_pkg.sv
// Shared types and constants for the display-to-sample aspect ratio unit.
// Holds the microprogram, the prime table and the control/status structs.
// No dependencies.
package dsar_pkg;

  // Field widths of the items.
  localparam int unsigned CODE_W = 4;
  localparam int unsigned SIZE_W = 14;
  localparam int unsigned TERM_W = 16;
  localparam int unsigned DAR_W  = 8;

  localparam logic [TERM_W-1:0] TERM_MAX = '1;

  // Aspect ratio information codes that select a display ratio.
  localparam logic [CODE_W-1:0] ASPECT_4_3    = 4'd2;
  localparam logic [CODE_W-1:0] ASPECT_16_9   = 4'd3;
  localparam logic [CODE_W-1:0] ASPECT_221_100 = 4'd4;

  // Prime table, walked in order by the reduction loop.
  localparam int unsigned PRIME_CNT   = 17;
  localparam int unsigned PRIME_W     = 6;
  localparam int unsigned PRIME_IDX_W = 5;
  localparam logic [PRIME_W-1:0] PRIME_TAB [PRIME_CNT] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29,
    6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53, 6'd59
  };

  // Datapath operations issued by the sequencer.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_TAKE_QUOT,
    OP_NEXT_PRIME,
    OP_EMIT
  } ucode_op_e;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_ZERO_BOTH,
    C_ODD,
    C_DIV_MORE,
    C_REM_NZ,
    C_STOP,
    C_OUT_BLOCKED
  } ucode_cond_e;

  localparam int unsigned PC_W = 4;

  typedef struct packed {
    ucode_op_e   op;
    ucode_cond_e cond;
    logic [PC_W-1:0] target;
  } ucode_word_t;

  // Status flags from the datapath that the jump conditions look at.
  typedef struct packed {
    logic no_input;
    logic zero_both;
    logic odd;
    logic div_more;
    logic rem_nz;
    logic stop;
    logic out_blocked;
  } dp_status_t;

  // Step addresses of the microprogram.
  localparam logic [PC_W-1:0] ST_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] ST_ZCHK     = 4'd1;
  localparam logic [PC_W-1:0] ST_HCHK     = 4'd2;
  localparam logic [PC_W-1:0] ST_HALVE    = 4'd3;
  localparam logic [PC_W-1:0] ST_DSTART   = 4'd4;
  localparam logic [PC_W-1:0] ST_DSTEP    = 4'd5;
  localparam logic [PC_W-1:0] ST_RCHK     = 4'd6;
  localparam logic [PC_W-1:0] ST_TAKE     = 4'd7;
  localparam logic [PC_W-1:0] ST_PCHK     = 4'd8;
  localparam logic [PC_W-1:0] ST_NEXT     = 4'd9;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd10;
  localparam logic [PC_W-1:0] ST_WRAP     = 4'd11;

  // Microprogram ROM: a jump is taken when its condition holds, else the
  // step counter advances by one.
  function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_word_t w;
    unique case (pc)
      ST_FETCH:  w = '{op: OP_LOAD,       cond: C_NO_INPUT,    target: ST_FETCH};
      ST_ZCHK:   w = '{op: OP_NOP,        cond: C_ZERO_BOTH,   target: ST_EMIT};
      ST_HCHK:   w = '{op: OP_NOP,        cond: C_ODD,         target: ST_DSTART};
      ST_HALVE:  w = '{op: OP_HALVE,      cond: C_ALWAYS,      target: ST_HCHK};
      ST_DSTART: w = '{op: OP_DIV_START,  cond: C_NEVER,       target: ST_FETCH};
      ST_DSTEP:  w = '{op: OP_DIV_STEP,   cond: C_DIV_MORE,    target: ST_DSTEP};
      ST_RCHK:   w = '{op: OP_NOP,        cond: C_REM_NZ,      target: ST_PCHK};
      ST_TAKE:   w = '{op: OP_TAKE_QUOT,  cond: C_ALWAYS,      target: ST_DSTART};
      ST_PCHK:   w = '{op: OP_NOP,        cond: C_STOP,        target: ST_EMIT};
      ST_NEXT:   w = '{op: OP_NEXT_PRIME, cond: C_ALWAYS,      target: ST_DSTART};
      ST_EMIT:   w = '{op: OP_EMIT,       cond: C_OUT_BLOCKED, target: ST_EMIT};
      ST_WRAP:   w = '{op: OP_NOP,        cond: C_ALWAYS,      target: ST_FETCH};
      default:   w = '{op: OP_NOP,        cond: C_ALWAYS,      target: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/dsar_div_lane.sv
// One lane of the restoring divider: divides by a small prime, one bit a cycle while step_i is high.
// Depends on dsar_pkg for the prime width.
module dsar_div_lane #(
  parameter int unsigned DW = 22
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [dsar_pkg::PRIME_W-1:0] divisor_i,
  output logic [DW-1:0]               quot_o,
  output logic                        rem_nz_o
);
  import dsar_pkg::*;

  logic [DW-1:0]      acc_q, acc_d;
  logic [PRIME_W-1:0] rem_q, rem_d;
  logic [PRIME_W:0]   trial;
  logic [PRIME_W:0]   diff;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, acc_q[DW-1]};
    diff  = trial - {1'b0, divisor_i};
    acc_d = acc_q;
    rem_d = rem_q;
    if (start_i) begin
      acc_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[PRIME_W-1:0];
        acc_d = {acc_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[PRIME_W-1:0];
        acc_d = {acc_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign quot_o   = acc_q;
  assign rem_nz_o = |rem_q;

endmodule

### hw/rtl/dsar_datapath.sv
// Datapath of the aspect ratio unit: term registers, multiplier, divider
// lanes, prime index and the output register. Depends on dsar_pkg and
// dsar_div_lane.
module dsar_datapath #(
  parameter int unsigned NUM_PRIMES = 17,
  parameter int unsigned SIZE_BITS  = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dsar_pkg::ucode_op_e    op_i,
  output dsar_pkg::dp_status_t   status_o,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,
  output logic                   m_axis_tuser
);
  import dsar_pkg::*;

  localparam int unsigned USED_W = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam int unsigned HV_W   = DAR_W + USED_W;
  localparam int unsigned CNT_W  = $clog2(HV_W + 1);
  localparam int unsigned IDX_W  = (NUM_PRIMES > 1) ? $clog2(NUM_PRIMES) : 1;

  logic [CODE_W-1:0] code;
  logic [USED_W-1:0] wid_used;
  logic [USED_W-1:0] hgt_used;
  logic [DAR_W-1:0]  dar_h, dar_v;
  logic              ratio;

  logic [HV_W-1:0]   h_q, h_d, v_q, v_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PRIME_W-1:0] prime;
  logic [HV_W-1:0]   quot_h, quot_v;
  logic              rem_nz_h, rem_nz_v;
  logic              div_start, div_step;

  logic              out_blocked, emit;
  logic              m_tvalid_q, m_tvalid_d;
  logic [31:0]       m_tdata_q, m_tdata_d;
  logic              m_tuser_q, m_tuser_d;

  // Unpack the input item; only the low size bits take part.
  assign code     = s_axis_tdata[3:0];
  assign wid_used = s_axis_tdata[4 +: USED_W];
  assign hgt_used = s_axis_tdata[18 +: USED_W];

  // Display ratio selected by the aspect code.
  always_comb begin
    ratio = 1'b1;
    unique case (code)
      ASPECT_4_3: begin
        dar_h = 8'd4;
        dar_v = 8'd3;
      end
      ASPECT_16_9: begin
        dar_h = 8'd16;
        dar_v = 8'd9;
      end
      ASPECT_221_100: begin
        dar_h = 8'd221;
        dar_v = 8'd100;
      end
      default: begin
        dar_h = '0;
        dar_v = '0;
        ratio = 1'b0;
      end
    endcase
  end

  assign prime = PRIME_TAB[PRIME_IDX_W'(idx_q)];

  // Both terms are divided by the same prime in parallel.
  assign div_start = (op_i == OP_DIV_START);
  assign div_step  = (op_i == OP_DIV_STEP);

  dsar_div_lane #(.DW(HV_W)) u_div_h (
    .clk_i      (clk_i),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (h_q),
    .divisor_i  (prime),
    .quot_o     (quot_h),
    .rem_nz_o   (rem_nz_h)
  );

  dsar_div_lane #(.DW(HV_W)) u_div_v (
    .clk_i      (clk_i),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (v_q),
    .divisor_i  (prime),
    .quot_o     (quot_v),
    .rem_nz_o   (rem_nz_v)
  );

  assign out_blocked = m_tvalid_q && !m_axis_tready;
  assign emit        = (op_i == OP_EMIT) && !out_blocked;

  // Term registers, prime index and bit counter.
  always_comb begin
    h_d   = h_q;
    v_d   = v_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    unique case (op_i)
      OP_LOAD: begin
        if (s_axis_tvalid) begin
          idx_d = '0;
          if (ratio) begin
            h_d = HV_W'(dar_h) * HV_W'(hgt_used);
            v_d = HV_W'(dar_v) * HV_W'(wid_used);
          end else begin
            h_d = HV_W'(1);
            v_d = HV_W'(1);
          end
        end
      end
      OP_HALVE: begin
        h_d = h_q >> 1;
        v_d = v_q >> 1;
      end
      OP_DIV_START: cnt_d = CNT_W'(HV_W);
      OP_DIV_STEP:  cnt_d = cnt_q - CNT_W'(1);
      OP_TAKE_QUOT: begin
        h_d = quot_h;
        v_d = quot_v;
      end
      OP_NEXT_PRIME: idx_d = idx_q + IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    v_q   <= v_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
  end

  // Output register holds one result item until it is taken.
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    if (emit) begin
      m_tvalid_d = 1'b1;
      m_tdata_d  = {v_q[TERM_W-1:0], h_q[TERM_W-1:0]};
      m_tuser_d  = (h_q > HV_W'(TERM_MAX)) || (v_q > HV_W'(TERM_MAX));
    end else if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  // Flags for the sequencer's jump conditions.
  always_comb begin
    status_o.no_input    = !s_axis_tvalid;
    status_o.zero_both   = (h_q == '0) && (v_q == '0);
    status_o.odd         = h_q[0] | v_q[0];
    status_o.div_more    = cnt_q > CNT_W'(1);
    status_o.rem_nz      = rem_nz_h | rem_nz_v;
    status_o.stop        = (v_q <= HV_W'(prime)) || (h_q <= HV_W'(prime)) ||
                           (idx_q == IDX_W'(NUM_PRIMES - 1));
    status_o.out_blocked = out_blocked;
  end

  assign s_axis_tready = (op_i == OP_LOAD);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

### hw/rtl/dsar_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on dsar_pkg for the microprogram and the status struct.
module dsar_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dsar_pkg::dp_status_t status_i,
  output dsar_pkg::ucode_op_e  op_o
);
  import dsar_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_word_t     word;
  logic            taken;

  assign word = ucode_rom(pc_q);

  // Evaluate the jump condition of the current step.
  always_comb begin
    unique case (word.cond)
      C_NEVER:       taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = status_i.no_input;
      C_ZERO_BOTH:   taken = status_i.zero_both;
      C_ODD:         taken = status_i.odd;
      C_DIV_MORE:    taken = status_i.div_more;
      C_REM_NZ:      taken = status_i.rem_nz;
      C_STOP:        taken = status_i.stop;
      C_OUT_BLOCKED: taken = status_i.out_blocked;
      default:       taken = 1'b1;
    endcase
  end

  // Next step: jump target or the following step.
  always_comb begin
    pc_d = taken ? word.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = word.op;

endmodule

### hw/rtl/display_to_sample_aspect_ratio_unit.sv
// Display-to-sample aspect ratio unit, top level.
// One item at a time. Each item goes through common halvings, then trial
// divisions by the primes in table order on a bit-serial divider over
// W = 8 + min(SIZE_BITS, 14) bits, then the emit step, which waits while the
// output register holds a result not yet taken. A ratio code with both sizes
// zero skips the reduction. After a result is written to the output register,
// the wrap step passes before the fetch step takes the next item. Reset
// returns the step counter to the fetch step and empties the output register.
module display_to_sample_aspect_ratio_unit #(
  parameter int unsigned NUM_PRIMES = 17,
  parameter int unsigned SIZE_BITS  = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // aspect_code[3:0], disp_width[17:4], disp_height[31:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sample_aspect_w[15:0], sample_aspect_h[31:16]
  output logic        m_axis_tuser    // truncated
);
  import dsar_pkg::*;

  ucode_op_e  op;
  dp_status_t status;

  dsar_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  dsar_datapath #(
    .NUM_PRIMES (NUM_PRIMES),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### dv/tb.sv
// Self-checking testbench for display_to_sample_aspect_ratio_unit.
// Drives aspect code and display size items, predicts each reduced sample aspect ratio.
// Depends on dsar_pkg and the unit RTL only.
`timescale 1ns / 100ps

module tb;
  import dsar_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned NUM_PRIMES     = 17;
  localparam int unsigned SIZE_BITS      = 14;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_TAIL     = 1200;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [15:0] RX_PATTERN_BITS = 16'b1011_0010_1110_0101;

  // Trial divisors of the reduction, in the order the unit walks them.
  localparam int unsigned DIVISORS [17] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59
  };

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RUNS,
    RX_PATTERN
  } rx_mode_e;

  typedef struct packed {
    logic [TERM_W-1:0] w;
    logic [TERM_W-1:0] h;
    logic              trunc;
  } sar_result_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    sar_result_t       sar;
  } sar_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  sar_entry_t  sar_expected_q [$];
  sar_entry_t  sar_front;

  rx_mode_e    rx_mode = RX_ALWAYS;
  bit          tx_idle_on = 1'b0;
  int unsigned tx_burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned rx_run_left = 0;
  logic [3:0]  rx_phase = '0;

  int unsigned items_sent = 0;
  int unsigned ratio_items = 0;
  int unsigned square_items = 0;
  int unsigned zero_size_items = 0;
  int unsigned results_checked = 0;
  int unsigned truncated_seen = 0;
  int unsigned mismatches = 0;
  int unsigned orphan_results = 0;

  display_to_sample_aspect_ratio_unit #(
    .NUM_PRIMES(NUM_PRIMES),
    .SIZE_BITS (SIZE_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Computes the reduced sample aspect ratio for one code and display size.
  function automatic sar_result_t predict_sar(input logic [CODE_W-1:0] code,
                                              input logic [SIZE_W-1:0] width,
                                              input logic [SIZE_W-1:0] height);
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] mask;
    int unsigned dar_num;
    int unsigned dar_den;
    int unsigned p;
    int unsigned i;
    bit          done;
    sar_result_t r;
    mask = (32'd1 << SIZE_BITS) - 32'd1;
    done = 1'b0;
    case (code)
      ASPECT_4_3: begin
        dar_num = 4;
        dar_den = 3;
      end
      ASPECT_16_9: begin
        dar_num = 16;
        dar_den = 9;
      end
      ASPECT_221_100: begin
        dar_num = 221;
        dar_den = 100;
      end
      default: begin
        r.w = TERM_W'(1);
        r.h = TERM_W'(1);
        r.trunc = 1'b0;
        return r;
      end
    endcase
    num = dar_num * (32'(height) & mask);
    den = dar_den * (32'(width) & mask);
    // Both terms zero are left alone; otherwise strip twos, then walk the divisors.
    if (num != 0 || den != 0) begin
      while (((num | den) & 32'd1) == 0) begin
        num = num >> 1;
        den = den >> 1;
      end
      for (i = 0; i < NUM_PRIMES && !done; i++) begin
        p = DIVISORS[i];
        while ((num % p) == 0 && (den % p) == 0) begin
          num = num / p;
          den = den / p;
        end
        if (den <= p || num <= p) done = 1'b1;
      end
    end
    r.w = num[TERM_W-1:0];
    r.h = den[TERM_W-1:0];
    r.trunc = (num > 32'hFFFF) || (den > 32'hFFFF);
    return r;
  endfunction

  // Offers one item, with a random gap ahead of it when the sender idles,
  // and records the expected result once the unit accepts it.
  task automatic send_item(input logic [CODE_W-1:0] code,
                           input logic [SIZE_W-1:0] width,
                           input logic [SIZE_W-1:0] height);
    int unsigned gap;
    sar_entry_t  entry;
    gap = 0;
    if (tx_idle_on) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, 12);
        tx_burst_left = $urandom_range(1, 8);
      end
      tx_burst_left--;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {height, width, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    entry.code   = code;
    entry.width  = width;
    entry.height = height;
    entry.sar    = predict_sar(code, width, height);
    sar_expected_q.push_back(entry);
    items_sent++;
    if (code == ASPECT_4_3 || code == ASPECT_16_9 || code == ASPECT_221_100) ratio_items++;
    else square_items++;
    if (width == 0 || height == 0) zero_size_items++;
  endtask

  // Drops tvalid right after the last acceptance and steps past that edge.
  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    stop_sending();
    while (sar_expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return ASPECT_4_3;
    if (pick < 58) return ASPECT_16_9;
    if (pick < 85) return ASPECT_221_100;
    return CODE_W'($urandom_range(0, 15));
  endfunction

  // Sizes lean toward values built from small primes so the reduction runs deep.
  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned pick;
    int unsigned v;
    int unsigned f;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return '1;
    if (pick < 40) return SIZE_W'($urandom_range(0, 16383));
    if (pick < 60) return SIZE_W'($urandom_range(1, 120));
    v = 1;
    n = $urandom_range(1, 7);
    repeat (n) begin
      f = DIVISORS[$urandom_range(0, NUM_PRIMES - 1)];
      if (v * f < 16384) v = v * f;
    end
    return SIZE_W'(v);
  endfunction

  // Every code that selects no display ratio, with zero, full and random sizes.
  task automatic test_square_codes();
    int unsigned c;
    rx_mode = RX_ALWAYS;
    tx_idle_on = 1'b0;
    for (c = 0; c < 16; c++) begin
      if (CODE_W'(c) != ASPECT_4_3 && CODE_W'(c) != ASPECT_16_9 &&
          CODE_W'(c) != ASPECT_221_100) begin
        case (c % 3)
          0: send_item(CODE_W'(c), '0, '0);
          1: send_item(CODE_W'(c), '1, '1);
          default: send_item(CODE_W'(c), rand_size(), rand_size());
        endcase
      end
    end
    wait_drain();
  endtask

  // Ratio codes with zero sizes, one zero size, full sizes and common formats.
  task automatic test_ratio_extremes();
    rx_mode = RX_ALWAYS;
    tx_idle_on = 1'b1;
    send_item(ASPECT_4_3, '0, '0);
    send_item(ASPECT_4_3, '1, '0);
    send_item(ASPECT_4_3, 14'd720, 14'd576);
    send_item(ASPECT_4_3, '1, '1);
    send_item(ASPECT_16_9, '0, '0);
    send_item(ASPECT_16_9, '0, '1);
    send_item(ASPECT_16_9, 14'd1920, 14'd1080);
    send_item(ASPECT_16_9, 14'd1, 14'd1);
    send_item(ASPECT_221_100, '0, '0);
    send_item(ASPECT_221_100, '1, '1);
    send_item(ASPECT_221_100, 14'd13, '0);
    send_item(ASPECT_221_100, 14'd352, 14'd288);
    wait_drain();
  endtask

  // Random items with both sides idling in runs.
  task automatic test_random_mixed(input int unsigned count);
    int unsigned k;
    rx_mode = RX_RUNS;
    tx_idle_on = 1'b1;
    for (k = 0; k < count; k++) send_item(rand_code(), rand_size(), rand_size());
    wait_drain();
  endtask

  // Random items with no idling on either side.
  task automatic test_back_to_back(input int unsigned count);
    int unsigned k;
    rx_mode = RX_ALWAYS;
    tx_idle_on = 1'b0;
    for (k = 0; k < count; k++) send_item(rand_code(), rand_size(), rand_size());
    wait_drain();
  endtask

  // The receiver holds off for a long stretch so the unit fills and stalls its input.
  task automatic test_output_hold(input int unsigned count);
    int unsigned k;
    rx_mode = RX_ALWAYS;
    tx_idle_on = 1'b0;
    hold_requests++;
    for (k = 0; k < count; k++) send_item(rand_code(), rand_size(), rand_size());
    wait_drain();
  endtask

  // Random items against a fixed ready pattern on the result side.
  task automatic test_pattern_stalls(input int unsigned count);
    int unsigned k;
    rx_mode = RX_PATTERN;
    tx_idle_on = 1'b1;
    for (k = 0; k < count; k++) send_item(rand_code(), rand_size(), rand_size());
    wait_drain();
  endtask

  // Result-side ready: long holds on request, otherwise the selected stall shape.
  always @(posedge clk_i) begin
    if (holds_done != hold_requests) begin
      holds_done    <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RUNS: begin
          if (rx_run_left == 0) begin
            m_axis_tready <= ($urandom_range(0, 99) < 60);
            rx_run_left   <= $urandom_range(1, 20);
          end else begin
            rx_run_left <= rx_run_left - 1;
          end
        end
        default: begin
          m_axis_tready <= RX_PATTERN_BITS[rx_phase];
          rx_phase      <= rx_phase + 4'd1;
        end
      endcase
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sar_expected_q.size() == 0) begin
        orphan_results++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result w=%0d h=%0d trunc=%0b with no item pending",
                   m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
      end else begin
        sar_front = sar_expected_q.pop_front();
        results_checked++;
        if (m_axis_tuser) truncated_seen++;
        if (m_axis_tdata[15:0] !== sar_front.sar.w ||
            m_axis_tdata[31:16] !== sar_front.sar.h ||
            m_axis_tuser !== sar_front.sar.trunc) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR: code=%0d width=%0d height=%0d exp w=%0d h=%0d trunc=%0b,",
                      " got w=%0d h=%0d trunc=%0b"},
                     sar_front.code, sar_front.width, sar_front.height,
                     sar_front.sar.w, sar_front.sar.h, sar_front.sar.trunc,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
        end
      end
    end
  end

  // Ends the run if no item moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no item moved for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, sar_expected_q.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_square_codes();
    test_ratio_extremes();
    test_random_mixed(275);
    test_back_to_back(100);
    test_output_hold(30);
    test_pattern_stalls(150);

    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sar_expected_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d expected results never arrived", sar_expected_q.size());
    end

    $display("Covered %0d items (%0d ratio codes, %0d square codes, %0d with a zero size).",
             items_sent, ratio_items, square_items, zero_size_items);
    $display("Checked %0d results, %0d truncated, %0d unexpected, %0d failures.",
             results_checked, truncated_seen, orphan_results, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dsar_pkg.sv
hw/rtl/dsar_div_lane.sv
hw/rtl/dsar_datapath.sv
hw/rtl/dsar_sequencer.sv
hw/rtl/display_to_sample_aspect_ratio_unit.sv
dv/tb.sv
